/* hdl/rsr_pkg.sv */
// ----------------------------------------------------------------------------
// Rolling Sharpe ratio package
// Shared constants, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package rsr_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int WP_W       = $clog2(MAX_WINDOW);
    localparam int LEN_W      = 9;
    localparam int AF_W       = 9;
    localparam int RF_W       = 16;
    localparam int PRICE_W    = 32;
    localparam int RET_W      = 32;
    localparam int SUM_W      = 48;
    localparam int SQ_W       = 64;
    localparam int MUL_A_W    = 48;
    localparam int MUL_B_W    = 32;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int DVD_W      = 64;
    localparam int DVS_W      = 32;
    localparam int ROOT_W     = 32;
    localparam int PADDR_W    = 4;

    localparam logic [LEN_W-1:0] WIN_LEN_RST = 9'd180;
    localparam logic [AF_W-1:0]  AF_RST      = 9'd365;
    localparam logic [RF_W-1:0]  RF_RST      = 16'd2621;
    localparam logic [LEN_W-1:0] MIN_LEN     = 9'd2;
    localparam logic [LEN_W:0]   MAX_LEN     = 10'(MAX_WINDOW);
    localparam logic [LEN_W:0]   BARS_MAX    = 10'(MAX_WINDOW + 2);

    localparam logic [RET_W-1:0] RET_SAT = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_WARMUP     = 2'd1,
        ST_ZERO_DEV   = 2'd2,
        ST_ZERO_PRICE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_WIN_LEN  = 2'd0,
        REG_ANN_FACT = 2'd1,
        REG_RF_RATE  = 2'd2,
        REG_NONE     = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RET,
        S_RD,
        S_OLD,
        S_SQO,
        S_SQN,
        S_CHK,
        S_MEAN,
        S_CORR,
        S_SQRT,
        S_NUM,
        S_FDIV,
        S_EMIT
    } t_state;

endpackage

/* hdl/rsr_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/rsr_mul.sv */
// ----------------------------------------------------------------------------
// Rolling Sharpe ratio serial multiplier
// Shift-and-add multiplier taking one bit of the second operand per cycle.
// ----------------------------------------------------------------------------
module rsr_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rsr_pkg::MUL_A_W-1:0]  i_a,
    input  logic [rsr_pkg::MUL_B_W-1:0]  i_b,
    output logic                         o_done,
    output logic [rsr_pkg::MUL_P_W-1:0]  o_prod
);
    import rsr_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_P_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= '0;
                r_a    <= MUL_P_W'(i_a);
                r_b    <= i_b;
                r_cnt  <= CNT_W'(MUL_B_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= {r_a[MUL_P_W-2:0], 1'b0};
                r_b   <= {1'b0, r_b[MUL_B_W-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* hdl/rsr_div.sv */
// ----------------------------------------------------------------------------
// Rolling Sharpe ratio serial divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rsr_pkg::DVD_W-1:0]  i_dvd,
    input  logic [rsr_pkg::DVS_W-1:0]  i_dvs,
    output logic                       o_done,
    output logic [rsr_pkg::DVD_W-1:0]  o_quo
);
    import rsr_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    assign trial = {r_rem, r_q[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dvd;
                r_rem  <= '0;
                r_dvs  <= i_dvs;
                r_cnt  <= CNT_W'(DVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_dvs}) begin
                    r_rem <= diff[DVS_W-1:0];
                    r_q   <= {r_q[DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[DVS_W-1:0];
                    r_q   <= {r_q[DVD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

/* hdl/rsr_sqrt.sv */
// ----------------------------------------------------------------------------
// Rolling Sharpe ratio serial square root
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rsr_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rsr_pkg::SQ_W-1:0]    i_val,
    output logic                        o_done,
    output logic [rsr_pkg::ROOT_W-1:0]  o_root
);
    import rsr_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;

    logic [SQ_W-1:0]   r_v;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W+1:0]  part;
    logic [REM_W+1:0]  trial;

    assign part  = {r_rem, r_v[SQ_W-1:SQ_W-2]};
    assign trial = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_val;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(ROOT_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_v <= {r_v[SQ_W-3:0], 2'b00};
                if (part >= trial) begin
                    r_rem  <= REM_W'(part - trial);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= REM_W'(part);
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hdl/rolling_sharpe_ratio_unit.sv */
// ----------------------------------------------------------------------------
// Rolling Sharpe ratio unit
// Takes one closing price per item and returns one annualized Sharpe ratio
// item over a sliding window of simple returns.
//
// The input stream carries a 32-bit close price per item. The output stream
// carries the Q16.16 ratio in tdata and valid_res and status in tuser.
// The APB port holds the window length, the annual factor and the risk-free
// rate; writing the window length restarts the window.
// One item is worked at a time by a sequencer around a shared bit-serial
// divider, multiplier and square root. Once the window is full an item's
// result is set by three divider passes, four multiplier passes and one
// root pass in series; the next item is accepted once the sequencer is back
// in idle. A warm-up item ends after the window update, the first item after
// a restart only stores its close, and a zero previous close skips the
// return division.
// Reset restores the register defaults and clears the window; the return
// memory needs no clearing. A finished result waits in the output register
// while the next item is accepted; a stalled receiver holds the sequencer
// only when the next result is ready to be placed.
// ----------------------------------------------------------------------------
module rolling_sharpe_ratio_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // close_price
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // sharpe
    output logic [2:0]                    m_tuser,   // valid_res, status[1:0]
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsr_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rsr_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [LEN_W-1:0]        r_win_len;
    logic [AF_W-1:0]         r_af;
    logic [RF_W-1:0]         r_rf;
    logic [PRICE_W-1:0]      r_prev;
    logic [PRICE_W-1:0]      r_c;
    logic [WP_W-1:0]         r_wp;
    logic [LEN_W-1:0]        r_bars;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sqsum;
    logic signed [RET_W-1:0] r_ret;
    logic signed [RET_W-1:0] r_old;
    logic                    r_cge;
    logic                    r_zflag;
    logic [MUL_B_W-1:0]      r_ms;
    logic                    r_msign;
    logic [ROOT_W-1:0]       r_d;
    logic                    r_nneg;
    logic [31:0]             r_res;
    logic                    r_res_vld;
    t_status                 r_res_st;
    logic                    r_mvalid;
    logic [31:0]             r_mdata;
    logic [2:0]              r_muser;

    logic                    cfg_wr;
    t_reg                    cfg_idx;
    logic [LEN_W-1:0]        n_eff;
    logic                    in_acc;
    logic [PRICE_W-1:0]      diff;
    logic                    mul_start;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic                    mul_done;
    logic [MUL_P_W-1:0]      mul_prod;
    logic                    div_start;
    logic [DVD_W-1:0]        div_dvd;
    logic [DVS_W-1:0]        div_dvs;
    logic                    div_done;
    logic [DVD_W-1:0]        div_quo;
    logic                    sqrt_start;
    logic [SQ_W-1:0]         sqrt_val;
    logic                    sqrt_done;
    logic [ROOT_W-1:0]       sqrt_root;
    logic                    ram_we;
    logic                    ram_re;
    logic [RET_W-1:0]        ram_rdata;
    logic [RET_W-1:0]        old_mag;
    logic [RET_W-1:0]        ret_mag;
    logic [SUM_W-1:0]        sum_mag;
    logic [SQ_W-1:0]         corr;
    logic [SQ_W-1:0]         sq_term;
    logic [RET_W-1:0]        rmag;
    logic signed [SUM_W-1:0] prod_s;
    logic signed [SUM_W-1:0] num;
    logic [SUM_W-1:0]        nmag;
    logic                    remove;
    logic                    warm;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_idx = t_reg'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_WIN_LEN:  prdata = 32'(r_win_len);
            REG_ANN_FACT: prdata = 32'(r_af);
            REG_RF_RATE:  prdata = 32'(r_rf);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        if (r_win_len < MIN_LEN) begin
            n_eff = MIN_LEN;
        end else if ({1'b0, r_win_len} > MAX_LEN) begin
            n_eff = LEN_W'(MAX_LEN);
        end else begin
            n_eff = r_win_len;
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign diff     = (s_tdata >= r_prev) ? s_tdata - r_prev : r_prev - s_tdata;

    assign old_mag  = ram_rdata[RET_W-1] ? RET_W'(-ram_rdata) : ram_rdata;
    assign ret_mag  = r_ret[RET_W-1] ? RET_W'(-r_ret) : RET_W'(r_ret);
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign corr     = mul_prod[SQ_W+15:16];
    assign sq_term  = mul_prod[SQ_W+15:16];
    assign remove   = ({1'b0, r_bars} - 10'd1) >= {1'b0, n_eff};
    assign warm     = {1'b0, r_bars} < ({1'b0, n_eff} + 10'd2);
    assign rmag     = (div_quo > DVD_W'(RET_SAT)) ? RET_SAT : div_quo[RET_W-1:0];
    assign prod_s   = r_msign ? SUM_W'(-mul_prod[SUM_W-1:0]) : SUM_W'(mul_prod[SUM_W-1:0]);
    assign num      = prod_s - SUM_W'({r_rf, 8'h00});
    assign nmag     = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);

    // Sequencer: next state and unit controls.
    always_comb begin
        n_state    = r_state;
        mul_start  = 1'b0;
        mul_a      = MUL_A_W'(ret_mag);
        mul_b      = ret_mag;
        div_start  = 1'b0;
        div_dvd    = {8'h00, diff, 24'h000000};
        div_dvs    = r_prev;
        sqrt_start = 1'b0;
        sqrt_val   = (r_sqsum >= corr) ? r_sqsum - corr : '0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_bars == '0) begin
                        n_state = S_CHK;
                    end else if (r_prev == '0) begin
                        n_state = S_RD;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_RET;
                    end
                end
            end
            S_RET: begin
                if (div_done) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_OLD;
            end
            S_OLD: begin
                mul_start = 1'b1;
                if (remove) begin
                    mul_a   = MUL_A_W'(old_mag);
                    mul_b   = old_mag;
                    n_state = S_SQO;
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_SQN;
                end
            end
            S_SQO: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    ram_we    = 1'b1;
                    n_state   = S_SQN;
                end
            end
            S_SQN: begin
                if (mul_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (warm) begin
                    n_state = S_EMIT;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'(sum_mag);
                    div_dvs   = DVS_W'(n_eff);
                    n_state   = S_MEAN;
                end
            end
            S_MEAN: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_a     = sum_mag;
                    mul_b     = div_quo[MUL_B_W-1:0];
                    n_state   = S_CORR;
                end
            end
            S_CORR: begin
                if (mul_done) begin
                    sqrt_start = 1'b1;
                    n_state    = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    if (sqrt_root == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = MUL_A_W'(r_ms);
                        mul_b     = MUL_B_W'(r_af);
                        n_state   = S_NUM;
                    end
                end
            end
            S_NUM: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'({nmag, 8'h00});
                    div_dvs   = r_d;
                    n_state   = S_FDIV;
                end
            end
            S_FDIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_mvalid || m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WIN_LEN_RST;
            r_af      <= AF_RST;
            r_rf      <= RF_RST;
            r_prev    <= '0;
            r_wp      <= '0;
            r_bars    <= '0;
            r_sum     <= '0;
            r_sqsum   <= '0;
            r_mvalid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_WIN_LEN: begin
                        r_win_len <= pwdata[LEN_W-1:0];
                        r_bars    <= '0;
                        r_wp      <= '0;
                        r_sum     <= '0;
                        r_sqsum   <= '0;
                    end
                    REG_ANN_FACT: r_af <= pwdata[AF_W-1:0];
                    REG_RF_RATE:  r_rf <= pwdata[RF_W-1:0];
                    default: ;
                endcase
            end
            if ((r_state == S_EMIT) && (!r_mvalid || m_tready)) begin
                r_mvalid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_c       <= s_tdata;
                        r_cge     <= s_tdata >= r_prev;
                        r_zflag   <= 1'b0;
                        r_res     <= '0;
                        r_res_vld <= 1'b0;
                        if (r_bars == '0) begin
                            r_prev <= s_tdata;
                            r_bars <= LEN_W'(1);
                        end else if (r_prev == '0) begin
                            r_zflag <= 1'b1;
                            r_ret   <= (s_tdata != '0) ? RET_SAT : '0;
                        end
                    end
                end
                S_RET: begin
                    if (div_done) begin
                        r_ret <= r_cge ? rmag : RET_W'(-rmag);
                    end
                end
                S_OLD: begin
                    r_old <= ram_rdata;
                end
                S_SQO: begin
                    if (mul_done) begin
                        r_sum   <= r_sum - SUM_W'(r_old);
                        r_sqsum <= r_sqsum - sq_term;
                    end
                end
                S_SQN: begin
                    if (mul_done) begin
                        r_sum   <= r_sum + SUM_W'(r_ret);
                        r_sqsum <= r_sqsum + sq_term;
                        r_prev  <= r_c;
                        r_wp    <= r_wp + 1'b1;
                        if ({1'b0, r_bars} < BARS_MAX) begin
                            r_bars <= r_bars + 1'b1;
                        end
                    end
                end
                S_CHK: begin
                    r_res_st <= ST_WARMUP;
                    r_msign  <= r_sum[SUM_W-1];
                end
                S_MEAN: begin
                    if (div_done) begin
                        r_ms <= div_quo[MUL_B_W-1:0];
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_d      <= sqrt_root;
                        r_res_st <= ST_ZERO_DEV;
                    end
                end
                S_NUM: begin
                    if (mul_done) begin
                        r_nneg <= !num[SUM_W-1];
                    end
                end
                S_FDIV: begin
                    if (div_done) begin
                        r_res_vld <= 1'b1;
                        r_res_st  <= r_zflag ? ST_ZERO_PRICE : ST_OK;
                        if (r_nneg) begin
                            r_res <= (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                : div_quo[31:0];
                        end else begin
                            r_res <= (div_quo > 64'h8000_0000) ? 32'h8000_0000
                                                                : 32'(-div_quo[31:0]);
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_mvalid || m_tready) begin
                        r_mdata  <= r_res;
                        r_muser  <= {r_res_st, r_res_vld};
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tuser  = r_muser;

    rsr_ram #(
        .WIDTH (RET_W),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_ret),
        .i_re    (ram_re),
        .i_raddr (r_wp - n_eff[WP_W-1:0]),
        .o_rdata (ram_rdata)
    );

    rsr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    rsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    rsr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (sqrt_val),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("Invalid result item carries a nonzero ratio.");

    a_valid_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |->
            (m_tuser[2:1] == ST_OK) || (m_tuser[2:1] == ST_ZERO_PRICE))
        else $error("Valid result item carries a failure status.");

    a_bars_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_bars} <= BARS_MAX)
        else $error("Bar counter passed its saturation value.");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_tready)
        else $error("A second item was taken before the first was finished.");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rolling Sharpe ratio unit testbench
// Drives close prices into the unit, predicts every ratio item from its own
// model of the return window and compares each output item field by field.
// Runs under several window and rate settings and several idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import rsr_pkg::*;

    typedef struct packed {
        logic [31:0] sharpe;
        logic        valid_res;
        t_status     status;
    } t_ratio;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // close_price
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // sharpe
    logic [2:0]  m_tuser;   // valid_res, status[1:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rolling_sharpe_ratio_unit u_top (.*);

    // Model state and registers.
    logic [8:0]  win_len_reg;
    logic [8:0]  ann_fact_reg;
    logic [15:0] rf_rate_reg;
    logic [31:0] prev_close;
    logic signed [31:0] ret_win [MAX_WINDOW];
    int unsigned win_ptr;
    int unsigned bar_count;
    longint      ret_sum;
    logic [63:0] ret_sq_sum;

    t_ratio      ratio_q[$];
    int          mismatch_cnt;
    int          idle_cnt;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    logic [31:0] walk_price;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] sq_term(logic signed [31:0] r);
        logic [63:0] a;
        a = r < 0 ? 64'(-longint'(r)) : 64'(r);
        return (a * a) >> 16;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_ratio predict_ratio(logic [31:0] c);
        t_ratio      o;
        int unsigned n;
        logic        zero_px;
        logic signed [31:0] r;
        logic [63:0] mag;
        longint      m;
        logic [63:0] ms, ss, corr, s, d, nmag, q;
        longint      num;
        n = win_len_reg < 2 ? 2 : (win_len_reg > MAX_WINDOW ? MAX_WINDOW : win_len_reg);
        zero_px = 1'b0;
        if (bar_count >= 1) begin
            if (prev_close == 0) begin
                zero_px = 1'b1;
                r = c != 0 ? 32'sh7FFF_FFFF : 32'sd0;
            end else if (c >= prev_close) begin
                mag = (64'(c - prev_close) << 24) / 64'(prev_close);
                if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
                r = mag[31:0];
            end else begin
                mag = (64'(prev_close - c) << 24) / 64'(prev_close);
                r = -$signed(mag[31:0]);
            end
            if (bar_count - 1 >= n) begin
                ret_sum = ret_sum - ret_win[(win_ptr + MAX_WINDOW - n) % MAX_WINDOW];
                ret_sq_sum = ret_sq_sum
                             - sq_term(ret_win[(win_ptr + MAX_WINDOW - n) % MAX_WINDOW]);
            end
            ret_win[win_ptr] = r;
            win_ptr = (win_ptr + 1) % MAX_WINDOW;
            ret_sum = ret_sum + r;
            ret_sq_sum = ret_sq_sum + sq_term(r);
        end
        prev_close = c;
        if (bar_count < MAX_WINDOW + 2) bar_count++;
        o.sharpe = 0;
        o.valid_res = 1'b0;
        o.status = ST_WARMUP;
        if (bar_count < n + 2) return o;
        m = ret_sum / longint'(n);
        ms = m < 0 ? 64'(-m) : 64'(m);
        ss = ret_sum < 0 ? 64'(-ret_sum) : 64'(ret_sum);
        corr = (ms >> 16) * ss + (((ms & 64'hFFFF) * ss) >> 16);
        s = ret_sq_sum >= corr ? ret_sq_sum - corr : 64'd0;
        d = int_sqrt(s);
        if (d == 0) begin
            o.status = ST_ZERO_DEV;
            return o;
        end
        num = m * longint'(ann_fact_reg) - (longint'(rf_rate_reg) << 8);
        nmag = num < 0 ? 64'(-num) : 64'(num);
        q = (nmag << 8) / d;
        if (num >= 0) o.sharpe = q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
        else o.sharpe = q > 64'h8000_0000 ? 32'h8000_0000 : 32'(-q);
        o.valid_res = 1'b1;
        o.status = zero_px ? ST_ZERO_PRICE : ST_OK;
        return o;
    endfunction

    task automatic send_price(logic [31:0] c);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        ratio_q.push_back(predict_ratio(c));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ratio_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [31:0] val);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WIN_LEN: begin
                win_len_reg = val[8:0];
                bar_count = 0;
                win_ptr = 0;
                ret_sum = 0;
                ret_sq_sum = 0;
            end
            REG_ANN_FACT: ann_fact_reg = val[8:0];
            REG_RF_RATE:  rf_rate_reg = val[15:0];
            default: ;
        endcase
    endtask

    // Next price of a random walk, with occasional noise items.
    task automatic send_walk();
        int unsigned k;
        logic [31:0] step;
        k = $urandom_range(99);
        if (k < 3) walk_price = 0;
        else if (k < 8) walk_price = $urandom;
        else if (k < 12) walk_price = walk_price;
        else begin
            if (walk_price < 1000) walk_price = $urandom_range(1000, 32'hFFFF_FFF);
            step = $urandom_range(0, walk_price >> $urandom_range(3, 10));
            if ($urandom_range(1) != 0 && walk_price < 32'hF000_0000) walk_price += step;
            else walk_price -= step;
        end
        send_price(walk_price);
    endtask

    task automatic test_directed();
        write_reg(REG_WIN_LEN, 2);
        send_price(32'hFFFF_FFFF);
        send_price(32'h0);
        send_price(32'h0);
        send_price(32'd100);
        send_price(32'd200);
        send_price(32'd150);
        send_price(32'd1);
        send_price(32'hFFFF_FFFF);
        send_price(32'hFFFF_FFFF);
        repeat (4) send_price(32'd5000);
        send_price(32'd5100);
        send_price(32'd4900);
        send_price(32'd5050);
        write_reg(REG_ANN_FACT, 0);
        write_reg(REG_RF_RATE, 16'hFFFF);
        repeat (5) send_price($urandom_range(900, 1100));
        write_reg(REG_ANN_FACT, 366);
        write_reg(REG_RF_RATE, 0);
        repeat (5) send_price($urandom_range(900, 1100));
    endtask

    task automatic test_window_clamp();
        write_reg(REG_WIN_LEN, 0);
        repeat (8) send_walk();
        write_reg(REG_WIN_LEN, 1);
        repeat (8) send_walk();
        write_reg(REG_WIN_LEN, 511);
        repeat (12) send_walk();
    endtask

    task automatic test_full_window();
        write_reg(REG_ANN_FACT, 252);
        write_reg(REG_WIN_LEN, 256);
        repeat (270) send_walk();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(REG_WIN_LEN, $urandom_range(2, 24));
        write_reg(REG_ANN_FACT, $urandom_range(1, 366));
        write_reg(REG_RF_RATE, $urandom_range(0, 16'hFFFF));
        repeat (25) send_walk();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_WIN_LEN, 3);
        hold_cycles = 3000;
        repeat (12) send_walk();
    endtask

    // Receiver side: random stalls plus a long hold-off set by the back-pressure test.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        t_ratio exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (ratio_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("Unexpected item: %h %b", m_tdata, m_tuser);
            end else begin
                exp_r = ratio_q.pop_front();
                if (m_tdata !== exp_r.sharpe || m_tuser[0] !== exp_r.valid_res
                        || m_tuser[2:1] !== exp_r.status) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("Mismatch: expected %h %b %0d, got %h %b %0d",
                                 exp_r.sharpe, exp_r.valid_res, exp_r.status,
                                 m_tdata, m_tuser[0], m_tuser[2:1]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 20000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatch_cnt = 0;
        idle_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        walk_price = 32'd100000;
        win_len_reg = WIN_LEN_RST;
        ann_fact_reg = AF_RST;
        rf_rate_reg = RF_RST;
        prev_close = 0;
        win_ptr = 0;
        bar_count = 0;
        ret_sum = 0;
        ret_sq_sum = 0;
        foreach (ret_win[i]) ret_win[i] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        repeat (4) send_walk();
        test_directed();
        test_window_clamp();
        test_full_window();
        test_random_phase(0, 0);
        test_random_phase(72, 0);
        test_random_phase(0, 72);
        test_random_phase(27, 27);
        test_backpressure();
        wait_drained();
        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
